FILE: rtl/core/ttb_pkg.sv
package ttb_pkg;

    localparam int OUT_WIDTH = 32;
    localparam int RESULT_FIELDS = 6;
    localparam int M_TDATA_WIDTH = OUT_WIDTH * RESULT_FIELDS;
    localparam int QUOT_SHIFT = 20;
    localparam int QUOT_BITS = 32;
    localparam int BIT_W = 5;
    localparam logic [OUT_WIDTH-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_WIDTH-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctrl_t;

endpackage

FILE: rtl/core/ttb_front.sv
module ttb_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [5*COORD_WIDTH-1:0]      in_data,
    output logic                          job_valid,
    input  logic                          job_ready,
    output logic [10*(COORD_WIDTH+1)-1:0] job_data
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;

    logic [1:0] corner_reg, corner_next;
    logic signed [CW-1:0] p0_reg [3];
    logic signed [CW-1:0] p1_reg [3];
    logic signed [CW-1:0] t0_reg [2];
    logic signed [CW-1:0] t1_reg [2];
    logic signed [CW-1:0] pos [3];
    logic signed [CW-1:0] tex [2];
    logic signed [DW-1:0] dp1 [3];
    logic signed [DW-1:0] dp2 [3];
    logic signed [DW-1:0] du1 [2];
    logic signed [DW-1:0] du2 [2];
    logic last_corner;
    logic accept;

    // Corner codes two and three both close a triangle; three never arises.
    assign last_corner = corner_reg[1];
    assign in_ready = !last_corner || job_ready;
    assign accept = in_valid && in_ready;
    assign job_valid = in_valid && last_corner;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos[i] = in_data[i*CW +: CW];
            dp1[i] = DW'(p1_reg[i]) - DW'(p0_reg[i]);
            dp2[i] = DW'(pos[i]) - DW'(p0_reg[i]);
        end
        for (int i = 0; i < 2; i++) begin
            tex[i] = in_data[(3+i)*CW +: CW];
            du1[i] = DW'(t1_reg[i]) - DW'(t0_reg[i]);
            du2[i] = DW'(tex[i]) - DW'(t0_reg[i]);
        end
        job_data = {du2[1], du2[0], du1[1], du1[0],
                    dp2[2], dp2[1], dp2[0], dp1[2], dp1[1], dp1[0]};
    end

    always_comb begin
        corner_next = corner_reg;
        if (accept) begin
            corner_next = last_corner ? CORNER_FIRST : corner_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= CORNER_FIRST;
        end else begin
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && corner_reg == CORNER_FIRST) begin
            p0_reg <= pos;
            t0_reg <= tex;
        end
        if (accept && corner_reg == CORNER_SECOND) begin
            p1_reg <= pos;
            t1_reg <= tex;
        end
    end

endmodule

FILE: rtl/core/ttb_queue.sv
module ttb_queue #(
    parameter int WIDTH = 170
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign in_ready = count_reg != 2'(DEPTH);
    assign out_valid = count_reg != 2'd0;
    assign out_data = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/core/ttb_div_lane.sv
module ttb_div_lane #(
    parameter int NUM_W = 37
) (
    input  logic                               aclk,
    input  ttb_pkg::lane_ctrl_t                ctrl,
    input  logic signed [NUM_W-1:0]            num,
    input  logic [NUM_W-1:0]                   den_mag,
    input  logic                               den_neg,
    output logic [ttb_pkg::OUT_WIDTH-1:0]      result
);

    localparam int NW = NUM_W + ttb_pkg::QUOT_SHIFT;
    localparam int DSW = NUM_W + ttb_pkg::QUOT_BITS - 1;

    logic [NW-1:0] rem_reg, rem_next;
    logic [DSW-1:0] ds_reg, ds_next;
    logic [ttb_pkg::QUOT_BITS-1:0] q_reg, q_next;
    logic neg_reg, neg_next;
    logic [NUM_W-1:0] num_mag;
    logic fits;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign fits = {{(DSW-NW){1'b0}}, rem_reg} >= ds_reg;

    always_comb begin
        rem_next = rem_reg;
        ds_next = ds_reg;
        q_next = q_reg;
        neg_next = neg_reg;
        if (ctrl.load) begin
            rem_next = {num_mag, {ttb_pkg::QUOT_SHIFT{1'b0}}};
            ds_next = {den_mag, {(ttb_pkg::QUOT_BITS-1){1'b0}}};
            q_next = '0;
            neg_next = num[NUM_W-1] ^ den_neg;
        end else if (ctrl.step) begin
            if (fits) begin
                rem_next = rem_reg - ds_reg[NW-1:0];
            end
            q_next = {q_reg[ttb_pkg::QUOT_BITS-2:0], fits};
            ds_next = ds_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        ds_reg <= ds_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
    end

    // A set top quotient bit means the result does not fit and saturates.
    always_comb begin
        if (q_reg[ttb_pkg::QUOT_BITS-1]) begin
            result = neg_reg ? ttb_pkg::SAT_MIN : ttb_pkg::SAT_MAX;
        end else begin
            result = neg_reg ? ttb_pkg::OUT_WIDTH'(-q_reg) : ttb_pkg::OUT_WIDTH'(q_reg);
        end
    end

endmodule

FILE: rtl/core/ttb_back.sv
module ttb_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  logic [10*(COORD_WIDTH+1)-1:0]     job_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ttb_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    output logic                              m_tuser
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int JOB_W = 10 * DW;
    localparam int PROD_W = 2 * DW;
    localparam int NUM_W = PROD_W + 1;
    localparam int SLOTS = 7;
    localparam logic [2:0] STEP_LAST = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [ttb_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic [JOB_W-1:0] job_reg, job_next;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic signed [NUM_W-1:0] num_reg [SLOTS];
    logic zero_det_reg, zero_det_next;
    logic out_valid_reg, out_valid_next;
    logic [ttb_pkg::M_TDATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic out_degen_reg, out_degen_next;

    logic signed [DW-1:0] dp1 [3];
    logic signed [DW-1:0] dp2 [3];
    logic signed [DW-1:0] du1u, du1v, du2u, du2v;
    logic signed [DW-1:0] mul_a, mul_b, mul_c, mul_d;
    logic slot_we;
    logic [2:0] slot_idx;
    logic [NUM_W-1:0] den_mag;
    logic out_free;
    logic take_job;
    ttb_pkg::lane_ctrl_t lane_ctrl;
    logic [ttb_pkg::OUT_WIDTH-1:0] lane_result [ttb_pkg::RESULT_FIELDS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dp1[i] = job_reg[i*DW +: DW];
            dp2[i] = job_reg[(3+i)*DW +: DW];
        end
        du1u = job_reg[6*DW +: DW];
        du1v = job_reg[7*DW +: DW];
        du2u = job_reg[8*DW +: DW];
        du2v = job_reg[9*DW +: DW];
    end

    // Slot zero takes the determinant, then the three tangent and three
    // bitangent numerators, each as the difference of two products.
    always_comb begin
        unique case (step_reg)
            3'd0: begin
                mul_a = du1u;   mul_b = du2v;   mul_c = du1v;   mul_d = du2u;
            end
            3'd1: begin
                mul_a = dp1[0]; mul_b = du2v;   mul_c = dp2[0]; mul_d = du1v;
            end
            3'd2: begin
                mul_a = dp1[1]; mul_b = du2v;   mul_c = dp2[1]; mul_d = du1v;
            end
            3'd3: begin
                mul_a = dp1[2]; mul_b = du2v;   mul_c = dp2[2]; mul_d = du1v;
            end
            3'd4: begin
                mul_a = dp2[0]; mul_b = du1u;   mul_c = dp1[0]; mul_d = du2u;
            end
            3'd5: begin
                mul_a = dp2[1]; mul_b = du1u;   mul_c = dp1[1]; mul_d = du2u;
            end
            3'd6: begin
                mul_a = dp2[2]; mul_b = du1u;   mul_c = dp1[2]; mul_d = du2u;
            end
            default: begin
                mul_a = '0;     mul_b = '0;     mul_c = '0;     mul_d = '0;
            end
        endcase
    end

    assign den_mag = num_reg[0][NUM_W-1] ? NUM_W'(-num_reg[0]) : NUM_W'(num_reg[0]);
    assign out_free = !out_valid_reg || m_tready;
    assign job_ready = (state_reg == ST_IDLE) || (state_reg == ST_FIN && out_free);
    assign take_job = job_valid && job_ready;

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        bit_next = bit_reg;
        job_next = job_reg;
        prod_a_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_b_next = PROD_W'(mul_c) * PROD_W'(mul_d);
        zero_det_next = zero_det_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_degen_next = out_degen_reg;
        slot_we = 1'b0;
        slot_idx = 3'(step_reg - 3'd1);
        lane_ctrl = '0;
        if (take_job) begin
            job_next = job_data;
            step_next = 3'd0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (take_job) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                slot_we = step_reg != 3'd0;
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                lane_ctrl.load = 1'b1;
                zero_det_next = num_reg[0] == '0;
                bit_next = ttb_pkg::BIT_W'(ttb_pkg::QUOT_BITS - 1);
                state_next = (num_reg[0] == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                lane_ctrl.step = 1'b1;
                bit_next = bit_reg - ttb_pkg::BIT_W'(1);
                if (bit_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_degen_next = zero_det_reg;
                    for (int i = 0; i < ttb_pkg::RESULT_FIELDS; i++) begin
                        out_data_next[i*ttb_pkg::OUT_WIDTH +: ttb_pkg::OUT_WIDTH] =
                            zero_det_reg ? '0 : lane_result[i];
                    end
                    state_next = take_job ? ST_MUL : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= 3'd0;
            bit_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            bit_reg <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        zero_det_reg <= zero_det_next;
        out_data_reg <= out_data_next;
        out_degen_reg <= out_degen_next;
        if (slot_we) begin
            num_reg[slot_idx] <= NUM_W'(prod_a_reg) - NUM_W'(prod_b_reg);
        end
    end

    for (genvar g = 0; g < ttb_pkg::RESULT_FIELDS; g++) begin : g_lane
        ttb_div_lane #(
            .NUM_W(NUM_W)
        ) u_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .num     (num_reg[g+1]),
            .den_mag (den_mag),
            .den_neg (num_reg[0][NUM_W-1]),
            .result  (lane_result[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_degen_reg;

endmodule

FILE: rtl/core/triangle_tangent_bitangent.sv
// Takes vertices one request at a time and groups them in order into triangles of three;
// the third vertex of each triangle yields one result with the tangent and bitangent in
// signed Q12.20, saturated, or all zeros with the degenerate flag in tuser when the UV
// determinant is zero. The front holds the first two corners and forms the deltas, a
// two-entry queue decouples it from the back, which forms the determinant and six
// numerators on two shared multipliers and then runs six restoring divide lanes; a
// degenerate triangle skips the divide. The back takes a new triangle only once it is
// done with the last one. The result waits in an output register; the back holds its
// next result in its final state until that register is free.
module triangle_tangent_bitangent #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up.
    input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z.
    output logic [ttb_pkg::M_TDATA_WIDTH-1:0]      m_tdata,
    // degenerate.
    output logic                                   m_tuser
);

    localparam int IN_W = 5 * COORD_WIDTH;
    localparam int JOB_W = 10 * (COORD_WIDTH + 1);

    logic front_valid;
    logic front_ready;
    logic [JOB_W-1:0] front_data;
    logic job_valid;
    logic job_ready;
    logic [JOB_W-1:0] job_data;

    ttb_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[IN_W-1:0]),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job_data  (front_data)
    );

    ttb_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (job_valid),
        .out_ready (job_ready),
        .out_data  (job_data)
    );

    ttb_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: bench/tb_triangle_tangent_bitangent.sv
`timescale 1ns / 1ps

module tb_triangle_tangent_bitangent;

    localparam int COORD_WIDTH = 16;
    localparam int TRIANGLES_PER_PHASE = 167;
    localparam int HOLD_CYCLES = 3000;
    localparam int HOLD_AFTER_RESULTS = 100;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        PHASE_SLOW_SINK,
        PHASE_SLOW_SOURCE,
        PHASE_FULL_RATE
    } phase_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] tex_v;
        logic [COORD_WIDTH-1:0] tex_u;
        logic [COORD_WIDTH-1:0] pos_z;
        logic [COORD_WIDTH-1:0] pos_y;
        logic [COORD_WIDTH-1:0] pos_x;
    } vertex_t;

    typedef struct {
        vertex_t v;
        phase_t  phase;
    } request_t;

    // vec[0..2] are tangent x/y/z, vec[3..5] bitangent x/y/z.
    typedef struct packed {
        logic                                                   degenerate;
        logic [ttb_pkg::RESULT_FIELDS-1:0][ttb_pkg::OUT_WIDTH-1:0] vec;
    } basis_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [$bits(vertex_t)-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [ttb_pkg::M_TDATA_WIDTH-1:0] m_tdata;
    logic                     m_tuser;

    request_t pending[$];
    basis_t   basis_due[$];
    phase_t   fill_phase = PHASE_SLOW_SINK;
    phase_t   send_phase = PHASE_SLOW_SINK;

    longint   corner_pos[2][3];
    longint   corner_tex[2][2];
    int       corner_idx = 0;

    int       results_seen = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       cycles = 0;
    bit       failed = 1'b0;

    string    field_name[ttb_pkg::RESULT_FIELDS] = '{"tangent_x", "tangent_y", "tangent_z",
                                            "bitangent_x", "bitangent_y", "bitangent_z"};

    triangle_tangent_bitangent #(
        .COORD_WIDTH(COORD_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int stall_pct(phase_t ph, bit sink);
        case (ph)
            PHASE_SLOW_SINK: begin
                return sink ? 79 : 11;
            end
            PHASE_SLOW_SOURCE: begin
                return sink ? 11 : 79;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    // Numerator scaled by 2^20 over the determinant, truncated toward zero and saturated.
    function automatic logic [ttb_pkg::OUT_WIDTH-1:0] q16_div(longint num, longint den);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic        neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        n = n << ttb_pkg::QUOT_SHIFT;
        d = (den < 0) ? -den : den;
        q = n / d;
        if (q >= 64'h8000_0000)
            return neg ? ttb_pkg::SAT_MIN : ttb_pkg::SAT_MAX;
        if (neg)
            q = -q;
        return q[ttb_pkg::OUT_WIDTH-1:0];
    endfunction

    task automatic take_corner(vertex_t v);
        longint p[3];
        longint t[2];
        longint dp1[3];
        longint dp2[3];
        longint du1[2];
        longint du2[2];
        longint det;
        longint tn;
        longint bn;
        basis_t b;
        p[0] = longint'($signed(v.pos_x));
        p[1] = longint'($signed(v.pos_y));
        p[2] = longint'($signed(v.pos_z));
        t[0] = longint'($signed(v.tex_u));
        t[1] = longint'($signed(v.tex_v));
        if (corner_idx < 2) begin
            for (int i = 0; i < 3; i++)
                corner_pos[corner_idx][i] = p[i];
            for (int i = 0; i < 2; i++)
                corner_tex[corner_idx][i] = t[i];
            corner_idx++;
            return;
        end
        corner_idx = 0;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = corner_pos[1][i] - corner_pos[0][i];
            dp2[i] = p[i] - corner_pos[0][i];
        end
        for (int i = 0; i < 2; i++) begin
            du1[i] = corner_tex[1][i] - corner_tex[0][i];
            du2[i] = t[i] - corner_tex[0][i];
        end
        det = du1[0] * du2[1] - du1[1] * du2[0];
        b = '0;
        if (det == 0) begin
            b.degenerate = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                tn = dp1[i] * du2[1] - dp2[i] * du1[1];
                bn = dp2[i] * du1[0] - dp1[i] * du2[0];
                b.vec[i] = q16_div(tn, det);
                b.vec[3+i] = q16_div(bn, det);
            end
        end
        basis_due.push_back(b);
    endtask

    task automatic queue_vertex(int px, int py, int pz, int u, int v);
        request_t r;
        r.v.pos_x = COORD_WIDTH'(px);
        r.v.pos_y = COORD_WIDTH'(py);
        r.v.pos_z = COORD_WIDTH'(pz);
        r.v.tex_u = COORD_WIDTH'(u);
        r.v.tex_v = COORD_WIDTH'(v);
        r.phase = fill_phase;
        pending.push_back(r);
    endtask

    // Mostly full-range vertices; some with tiny UV spans for degenerate and saturated
    // triangles, some with moderate values that keep the quotients in range.
    task automatic queue_random_triangle();
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
            if (mode < 6) begin
                queue_vertex($urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (mode < 8) begin
                queue_vertex($urandom, $urandom, $urandom,
                             int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3);
            end else begin
                queue_vertex(int'($urandom_range(4095)) - 2048,
                             int'($urandom_range(4095)) - 2048,
                             int'($urandom_range(4095)) - 2048,
                             int'($urandom_range(8191)) - 4096,
                             int'($urandom_range(8191)) - 4096);
            end
        end
    endtask

    task automatic check_basis();
        basis_t want;
        basis_t got;
        got = {m_tuser, m_tdata};
        if (basis_due.size() == 0) begin
            $error("result with no request waiting: tuser %0b tdata %h", m_tuser, m_tdata);
            failed = 1'b1;
            return;
        end
        want = basis_due.pop_front();
        for (int i = 0; i < ttb_pkg::RESULT_FIELDS; i++) begin
            if (got.vec[i] !== want.vec[i]) begin
                $error("%s: expected %h, actual %h", field_name[i], want.vec[i], got.vec[i]);
                failed = 1'b1;
            end
        end
        if (got.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, actual %0b", want.degenerate, got.degenerate);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                take_corner(vertex_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 &&
                    $urandom_range(99) >= stall_pct(pending[0].phase, 1'b0)) begin
                    s_tdata <= pending[0].v;
                    send_phase <= pending[0].phase;
                    s_tvalid <= 1'b1;
                    void'(pending.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side, so that the block backs up into its input.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_basis();
                results_seen <= results_seen + 1;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct(send_phase, 1'b1));
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** triangle_tangent_bitangent: FAILED **");
            $finish;
        end
    end

    initial begin
        // All-zero triangle.
        queue_vertex(0, 0, 0, 0, 0);
        queue_vertex(0, 0, 0, 0, 0);
        queue_vertex(0, 0, 0, 0, 0);
        // Unit determinant with extreme edges: the nonzero fields saturate high.
        queue_vertex(-32768, -32768, -32768, 0, 0);
        queue_vertex(32767, 32767, 32767, 1, 0);
        queue_vertex(-32768, 32767, 0, 0, 1);
        // The same edges reversed: the nonzero fields saturate low.
        queue_vertex(32767, 32767, 32767, 0, 0);
        queue_vertex(-32768, -32768, -32768, 1, 0);
        queue_vertex(32767, -32768, 0, 0, 1);
        // Extreme texture coordinates, largest determinant.
        queue_vertex(0, 0, 0, -32768, -32768);
        queue_vertex(256, 0, 0, 32767, -32768);
        queue_vertex(0, 256, 0, -32768, 32767);
        // Negative determinant.
        queue_vertex(0, 0, 0, 0, 0);
        queue_vertex(256, 512, -256, 0, 4096);
        queue_vertex(-256, 128, 768, 4096, 0);
        // Collinear texture coordinates give a zero determinant.
        queue_vertex(100, -200, 300, 100, 200);
        queue_vertex(-400, 500, 600, 200, 400);
        queue_vertex(700, 800, -900, 300, 600);
        // Alternating bit patterns.
        queue_vertex(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'hAAAA);
        queue_vertex(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hFFFF, 16'h0000);
        queue_vertex(16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000);
        // Coincident positions with a negative determinant give zero vectors.
        queue_vertex(1234, -1234, 77, 0, 0);
        queue_vertex(1234, -1234, 77, 0, 4096);
        queue_vertex(1234, -1234, 77, 4096, 0);

        for (int ph = PHASE_SLOW_SINK; ph <= PHASE_FULL_RATE; ph++) begin
            fill_phase = phase_t'(ph);
            for (int n = 0; n < TRIANGLES_PER_PHASE; n++)
                queue_random_triangle();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (basis_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (basis_due.size() != 0) begin
            $error("%0d expected results never arrived", basis_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("** triangle_tangent_bitangent: PASSED **");
        end else begin
            $display("** triangle_tangent_bitangent: FAILED **");
        end
        $finish;
    end

endmodule
